// ===== hw/rtl/lbpm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbpm_pkg
// Types and constants shared by the light bar pair matcher.
// ----------------------------------------------------------------------------
package lbpm_pkg;

    localparam int unsigned CfgIdxW    = 2;
    localparam int unsigned CfgDataW   = 14;
    localparam int unsigned ResultCap  = 28;
    localparam int unsigned HalfTurn   = 11520;
    localparam int unsigned RootSteps  = 17;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_ANGLE_TOL = 2'd0,
        CFG_SIZE_DIV  = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [13:0] tilt;
        logic [15:0] bar_width;
        logic [15:0] bar_height;
        logic        last_bar;
    } t_in_word;

    typedef struct packed {
        logic        match_valid;
        logic [2:0]  first_index;
        logic [2:0]  second_index;
        logic [16:0] mid_x;
        logic [16:0] mid_y;
        logic [15:0] pair_angle;
        logic [12:0] long_side;
        logic [12:0] short_side;
        logic        dropped_bars;
        logic        last_result;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_SQ_X,
        S_SQ_Y,
        S_ROOT,
        S_PUSH,
        S_NEXT,
        S_FLUSH
    } t_state;

endpackage
`default_nettype wire

// ===== hw/rtl/light_bar_pair_matcher_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// light_bar_pair_matcher_top
// Pairs fitted light bar ellipses of one frame into armor candidates.
// ----------------------------------------------------------------------------
// Bars load one per cycle into a small store. The bar marked last_bar starts
// the pair scan, during which the input stalls. Each pair takes a store
// read, a test and an advance; a matching pair then squares dx and dy on the
// shared 16x16 multiplier, runs the bit-serial square root and pushes its
// result, and an output stall can hold the push. Results are held one deep
// so the final one can carry last_result; a frame with no match yields one
// empty word. Bars beyond MAX_BARS are dropped and flagged on every result
// of the frame.
module light_bar_pair_matcher_top
    import lbpm_pkg::*;
#(
    parameter int unsigned MAX_BARS = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire t_in_word            i_data,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output t_out_word                o_data,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [CfgDataW-1:0] i_cfg_data
);

    localparam int unsigned CW = $clog2(MAX_BARS + 1);
    localparam int unsigned IW = $clog2(MAX_BARS);

    t_state r_state, n_state;

    logic [13:0] r_tol;
    logic [3:0]  r_div;

    logic [15:0] mem_cx   [MAX_BARS];
    logic [15:0] mem_cy   [MAX_BARS];
    logic [13:0] mem_tilt [MAX_BARS];
    logic [15:0] mem_w    [MAX_BARS];
    logic [15:0] mem_h    [MAX_BARS];

    logic [CW-1:0] r_cnt;
    logic          r_ovf;
    logic [CW-1:0] r_i, r_j;
    logic [4:0]    r_nmatch;
    logic          r_have_pend;
    t_out_word     r_pend;

    logic [15:0] r_cxi, r_cxj, r_cyi, r_cyj, r_wi, r_wj, r_hi, r_hj;
    logic [13:0] r_ti, r_tj;
    logic        r_anti;
    logic [15:0] r_dx, r_dy;
    logic [32:0] r_acc;
    logic [32:0] r_rad;
    logic [33:0] r_root;
    logic [32:0] r_bit;
    logic [4:0]  r_step;

    logic          r_out_valid;
    t_out_word     r_out;

    // control decode
    logic w_accept, w_store, w_out_free, w_match, w_last_step;
    logic w_push_pend, w_flush_out;
    logic [CW-1:0] w_cnt_after;

    // datapath combinational
    logic [13:0] w_d0, w_d;
    logic        w_par, w_anti;
    logic        w_h_ok, w_w_ok;
    logic [15:0] w_hd, w_wd;
    logic [19:0] w_hd_mul, w_wd_mul;
    logic [16:0] w_h_sum, w_w_sum;
    logic [14:0] w_anti_sum;
    logic [15:0] w_mul_a;
    logic [31:0] w_prod;
    logic [33:0] w_trial;
    logic [12:0] w_nl, w_nw;
    t_out_word   w_new;
    t_out_word   w_empty;

    assign w_accept    = i_valid && !o_stall;
    assign w_store     = r_cnt < CW'(MAX_BARS);
    assign w_cnt_after = w_store ? r_cnt + CW'(1) : r_cnt;
    assign w_out_free  = !r_out_valid || !i_stall;
    assign w_last_step = r_step == 5'd0;

    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;

    // angle and size tests
    assign w_d0       = (r_ti > r_tj) ? r_ti - r_tj : r_tj - r_ti;
    assign w_d        = (w_d0 > 14'(HalfTurn)) ? w_d0 - 14'(HalfTurn) : w_d0;
    assign w_par      = w_d < r_tol;
    assign w_anti_sum = {1'b0, w_d} + {1'b0, r_tol};
    assign w_anti     = w_anti_sum > 15'(HalfTurn);
    assign w_hd       = (r_hi > r_hj) ? r_hi - r_hj : r_hj - r_hi;
    assign w_wd       = (r_wi > r_wj) ? r_wi - r_wj : r_wj - r_wi;
    assign w_hd_mul   = w_hd * r_div;
    assign w_wd_mul   = w_wd * r_div;
    assign w_h_sum    = {1'b0, r_hi} + {1'b0, r_hj};
    assign w_w_sum    = {1'b0, r_wi} + {1'b0, r_wj};
    assign w_h_ok     = w_hd_mul < {3'b0, w_h_sum};
    assign w_w_ok     = w_wd_mul < {3'b0, w_w_sum};
    assign w_match    = (w_par || w_anti) && w_h_ok && w_w_ok;

    assign w_mul_a = (r_state == S_SQ_X) ? r_dx : r_dy;
    assign w_prod  = w_mul_a * w_mul_a;
    assign w_trial = r_root + {1'b0, r_bit};

    assign w_nl = 13'(w_h_sum >> 5);
    assign w_nw = 13'(r_root >> 4);

    always_comb begin
        w_new              = '0;
        w_new.match_valid  = 1'b1;
        w_new.first_index  = 3'(r_i);
        w_new.second_index = 3'(r_j);
        w_new.mid_x        = {1'b0, r_cxi} + {1'b0, r_cxj};
        w_new.mid_y        = {1'b0, r_cyi} + {1'b0, r_cyj};
        w_new.pair_angle   = 16'({2'b0, r_ti} + {2'b0, r_tj})
                           + (r_anti ? 16'(HalfTurn) : 16'd0);
        w_new.long_side    = (w_nl < w_nw) ? w_nw : w_nl;
        w_new.short_side   = (w_nl < w_nw) ? w_nl : w_nw;
        w_new.dropped_bars = r_ovf;
        w_new.last_result  = 1'b0;

        w_empty              = '0;
        w_empty.dropped_bars = r_ovf;
        w_empty.last_result  = 1'b1;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_data.last_bar) begin
                    n_state = (w_cnt_after < CW'(2)) ? S_FLUSH : S_READ;
                end
            end
            S_READ:  n_state = S_CHECK;
            S_CHECK: n_state = w_match ? S_SQ_X : S_NEXT;
            S_SQ_X:  n_state = S_SQ_Y;
            S_SQ_Y:  n_state = S_ROOT;
            S_ROOT:  n_state = w_last_step ? S_PUSH : S_ROOT;
            S_PUSH: begin
                if (!r_have_pend || w_out_free) begin
                    n_state = (r_nmatch == 5'(ResultCap - 1)) ? S_FLUSH : S_NEXT;
                end
            end
            S_NEXT: begin
                if ((r_j + CW'(1) < r_cnt) || (r_i + CW'(2) < r_cnt)) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: n_state = w_out_free ? S_IDLE : S_FLUSH;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_stall     = 1'b1;
        w_push_pend = 1'b0;
        w_flush_out = 1'b0;
        unique case (r_state)
            S_IDLE:  o_stall     = 1'b0;
            S_PUSH:  w_push_pend = r_have_pend && w_out_free;
            S_FLUSH: w_flush_out = w_out_free;
            default: o_stall     = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tol       <= 14'd128;
            r_div       <= 4'd5;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_have_pend <= 1'b0;
            r_nmatch    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ANGLE_TOL: r_tol <= i_cfg_data;
                    CFG_SIZE_DIV:  r_div <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_cnt       <= w_cnt_after;
                r_have_pend <= 1'b0;
                r_nmatch    <= '0;
                if (!w_store) begin
                    r_ovf <= 1'b1;
                end
            end
            if (r_state == S_PUSH && (!r_have_pend || w_out_free)) begin
                r_have_pend <= 1'b1;
                r_nmatch    <= r_nmatch + 5'd1;
            end
            if (w_flush_out) begin
                r_cnt <= '0;
                r_ovf <= 1'b0;
            end
            if (w_push_pend || w_flush_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_store) begin
            mem_cx[r_cnt[IW-1:0]]   <= i_data.center_x;
            mem_cy[r_cnt[IW-1:0]]   <= i_data.center_y;
            mem_tilt[r_cnt[IW-1:0]] <= i_data.tilt;
            mem_w[r_cnt[IW-1:0]]    <= i_data.bar_width;
            mem_h[r_cnt[IW-1:0]]    <= i_data.bar_height;
        end
        if (r_state == S_READ) begin
            r_cxi <= mem_cx[r_i[IW-1:0]];
            r_cxj <= mem_cx[r_j[IW-1:0]];
            r_cyi <= mem_cy[r_i[IW-1:0]];
            r_cyj <= mem_cy[r_j[IW-1:0]];
            r_ti  <= mem_tilt[r_i[IW-1:0]];
            r_tj  <= mem_tilt[r_j[IW-1:0]];
            r_wi  <= mem_w[r_i[IW-1:0]];
            r_wj  <= mem_w[r_j[IW-1:0]];
            r_hi  <= mem_h[r_i[IW-1:0]];
            r_hj  <= mem_h[r_j[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_i <= '0;
            r_j <= CW'(1);
        end
        if (r_state == S_NEXT) begin
            if (r_j + CW'(1) < r_cnt) begin
                r_j <= r_j + CW'(1);
            end else begin
                r_i <= r_i + CW'(1);
                r_j <= r_i + CW'(2);
            end
        end
        if (r_state == S_CHECK) begin
            r_anti <= w_anti;
            r_dx   <= (r_cxi > r_cxj) ? r_cxi - r_cxj : r_cxj - r_cxi;
            r_dy   <= (r_cyi > r_cyj) ? r_cyi - r_cyj : r_cyj - r_cyi;
        end
        if (r_state == S_SQ_X) begin
            r_acc <= {1'b0, w_prod};
        end
        if (r_state == S_SQ_Y) begin
            r_rad  <= r_acc + {1'b0, w_prod};
            r_root <= '0;
            r_bit  <= 33'(1) << 32;
            r_step <= 5'(RootSteps - 1);
        end
        if (r_state == S_ROOT) begin
            if ({1'b0, r_rad} >= w_trial) begin
                r_rad  <= 33'({1'b0, r_rad} - w_trial);
                r_root <= (r_root >> 1) + {1'b0, r_bit};
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit  <= r_bit >> 2;
            r_step <= r_step - 5'd1;
        end
        if (r_state == S_PUSH && (!r_have_pend || w_out_free)) begin
            r_pend <= w_new;
        end
        if (w_push_pend) begin
            r_out <= r_pend;
        end else if (w_flush_out) begin
            if (r_have_pend) begin
                r_out             <= r_pend;
                r_out.last_result <= 1'b1;
            end else begin
                r_out <= w_empty;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/lbpm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbpm_checker
// Port-level checks for the light bar pair matcher.
// ----------------------------------------------------------------------------
module lbpm_checker
    import lbpm_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_valid,
    input wire logic      o_stall,
    input wire t_in_word  i_data,
    input wire logic      o_valid,
    input wire logic      i_stall,
    input wire t_out_word o_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result word changed while stalled");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.match_valid |-> o_data.last_result)
        else $error("empty result not marked last");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.match_valid |->
            o_data.mid_x == 17'd0 && o_data.mid_y == 17'd0 &&
            o_data.long_side == 13'd0 && o_data.pair_angle == 16'd0)
        else $error("empty result carries data");

    a_side_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.match_valid |-> o_data.long_side >= o_data.short_side)
        else $error("long side below short side");

    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_data.last_bar |=> o_stall)
        else $error("input not stalled after last bar");

endmodule

bind light_bar_pair_matcher_top lbpm_checker u_lbpm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
`default_nettype wire

// ===== bench/tb_light_bar_pair_matcher_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_light_bar_pair_matcher_top
// Self-checking bench for the light bar pair matcher. Frames of bars are sent
// through the input handshake while a predictor pairs them the same way and
// queues the pair words it expects; a monitor compares every output word.
// ----------------------------------------------------------------------------
module tb_light_bar_pair_matcher_top;
    import lbpm_pkg::*;

    localparam int NBARS = 8;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in_word i_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_out_word o_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CfgIdxW-1:0] i_cfg_index = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off = 0;
    int errors = 0;

    logic [13:0] tol_q = 14'd128;
    logic [3:0] div_q = 4'd5;
    logic [15:0] bar_cx[NBARS];
    logic [15:0] bar_cy[NBARS];
    logic [13:0] bar_tilt[NBARS];
    logic [15:0] bar_w[NBARS];
    logic [15:0] bar_h[NBARS];
    int bar_num = 0;
    logic bars_dropped = 1'b0;
    t_out_word pair_words_q[$];

    light_bar_pair_matcher_top #(.MAX_BARS(NBARS)) dut (.*);

    always #6 i_clk = ~i_clk;

    initial begin
        #200ms;
        $display("tb_light_bar_pair_matcher_top failed");
        $finish;
    end

    // receiver stall: random, or a long hold-off counted in cycles
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pair_words_q.size() == 0) begin
                $error("unexpected word %h", o_data);
                errors++;
            end else begin
                exp_w = pair_words_q.pop_front();
                if (o_data.match_valid !== exp_w.match_valid) begin
                    $error("match_valid exp %h got %h", exp_w.match_valid, o_data.match_valid);
                    errors++;
                end
                if (o_data.first_index !== exp_w.first_index) begin
                    $error("first_index exp %h got %h", exp_w.first_index, o_data.first_index);
                    errors++;
                end
                if (o_data.second_index !== exp_w.second_index) begin
                    $error("second_index exp %h got %h", exp_w.second_index,
                        o_data.second_index);
                    errors++;
                end
                if (o_data.mid_x !== exp_w.mid_x) begin
                    $error("mid_x exp %h got %h", exp_w.mid_x, o_data.mid_x);
                    errors++;
                end
                if (o_data.mid_y !== exp_w.mid_y) begin
                    $error("mid_y exp %h got %h", exp_w.mid_y, o_data.mid_y);
                    errors++;
                end
                if (o_data.pair_angle !== exp_w.pair_angle) begin
                    $error("pair_angle exp %h got %h", exp_w.pair_angle, o_data.pair_angle);
                    errors++;
                end
                if (o_data.long_side !== exp_w.long_side) begin
                    $error("long_side exp %h got %h", exp_w.long_side, o_data.long_side);
                    errors++;
                end
                if (o_data.short_side !== exp_w.short_side) begin
                    $error("short_side exp %h got %h", exp_w.short_side, o_data.short_side);
                    errors++;
                end
                if (o_data.dropped_bars !== exp_w.dropped_bars) begin
                    $error("dropped_bars exp %h got %h", exp_w.dropped_bars,
                        o_data.dropped_bars);
                    errors++;
                end
                if (o_data.last_result !== exp_w.last_result) begin
                    $error("last_result exp %h got %h", exp_w.last_result, o_data.last_result);
                    errors++;
                end
            end
        end
    end

    function automatic logic [31:0] floor_root(logic [33:0] v);
        logic [33:0] r;
        r = 0;
        for (int b = 16; b >= 0; b--) begin
            if ((r | (34'd1 << b)) * (r | (34'd1 << b)) <= v)
                r = r | (34'd1 << b);
        end
        return r[31:0];
    endfunction

    function automatic logic sizes_match(logic [15:0] a, logic [15:0] b);
        logic [16:0] d;
        d = (a > b) ? a - b : b - a;
        return (21'(d) * div_q) < ({1'b0, a} + b);
    endfunction

    task automatic pair_frame();
        int n;
        int d;
        logic par;
        logic anti;
        logic [16:0] dx;
        logic [16:0] dy;
        logic [16:0] nl;
        logic [31:0] nw;
        t_out_word w;
        n = 0;
        for (int i = 0; i + 1 < bar_num && n < ResultCap; i++) begin
            for (int j = i + 1; j < bar_num && n < ResultCap; j++) begin
                d = (bar_tilt[i] > bar_tilt[j]) ? bar_tilt[i] - bar_tilt[j]
                                                : bar_tilt[j] - bar_tilt[i];
                if (d > HalfTurn)
                    d = d - HalfTurn;
                par = d < int'(tol_q);
                anti = (int'(HalfTurn) - d) < int'(tol_q);
                if ((par || anti) && sizes_match(bar_h[i], bar_h[j])
                        && sizes_match(bar_w[i], bar_w[j])) begin
                    dx = (bar_cx[i] > bar_cx[j]) ? bar_cx[i] - bar_cx[j] : bar_cx[j] - bar_cx[i];
                    dy = (bar_cy[i] > bar_cy[j]) ? bar_cy[i] - bar_cy[j] : bar_cy[j] - bar_cy[i];
                    nl = ({1'b0, bar_h[i]} + bar_h[j]) >> 5;
                    nw = floor_root(dx * dx + dy * dy) >> 4;
                    w = '0;
                    w.match_valid = 1'b1;
                    w.first_index = i[2:0];
                    w.second_index = j[2:0];
                    w.mid_x = {1'b0, bar_cx[i]} + bar_cx[j];
                    w.mid_y = {1'b0, bar_cy[i]} + bar_cy[j];
                    w.pair_angle = 16'(bar_tilt[i] + bar_tilt[j] + (anti ? HalfTurn : 0));
                    w.long_side = (nl < nw) ? nw[12:0] : nl[12:0];
                    w.short_side = (nl < nw) ? nl[12:0] : nw[12:0];
                    w.dropped_bars = bars_dropped;
                    pair_words_q = {pair_words_q, w};
                    n++;
                end
            end
        end
        if (n == 0) begin
            w = '0;
            w.dropped_bars = bars_dropped;
            pair_words_q = {pair_words_q, w};
        end
        pair_words_q[$].last_result = 1'b1;
        bar_num = 0;
        bars_dropped = 1'b0;
    endtask

    task automatic send_bar(t_in_word b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= b;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        if (bar_num < NBARS) begin
            bar_cx[bar_num] = b.center_x;
            bar_cy[bar_num] = b.center_y;
            bar_tilt[bar_num] = b.tilt;
            bar_w[bar_num] = b.bar_width;
            bar_h[bar_num] = b.bar_height;
            bar_num++;
        end else begin
            bars_dropped = 1'b1;
        end
        if (b.last_bar)
            pair_frame();
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pair_words_q.size() != 0)
            @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CfgDataW-1:0] val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_ANGLE_TOL)
            tol_q = val;
        else
            div_q = val[3:0];
    endtask

    function automatic t_in_word rand_bar(logic last);
        t_in_word b;
        b.center_x = 16'($urandom);
        b.center_y = 16'($urandom);
        b.tilt = ($urandom_range(9) == 0) ? 14'($urandom) : 14'($urandom_range(11520));
        b.bar_width = 16'($urandom);
        b.bar_height = 16'($urandom);
        b.last_bar = last;
        return b;
    endfunction

    // bars alike in size and tilt so that most pairs match
    function automatic t_in_word like_bar(t_in_word base, logic last);
        t_in_word b;
        b = base;
        b.center_x = 16'($urandom);
        b.center_y = 16'($urandom);
        b.tilt = 14'(($urandom_range(1) ? base.tilt : 14'((base.tilt + 11520) % 16384))
            + $urandom_range(40));
        b.bar_width = 16'(base.bar_width + $urandom_range(base.bar_width / 16));
        b.bar_height = 16'(base.bar_height + $urandom_range(base.bar_height / 16));
        b.last_bar = last;
        return b;
    endfunction

    task automatic send_frame(int n, int alike);
        t_in_word base;
        base = rand_bar(1'b0);
        base.tilt = 14'($urandom_range(11520));
        base.bar_width = 16'($urandom_range(60000, 100));
        base.bar_height = 16'($urandom_range(60000, 100));
        for (int k = 0; k < n; k++)
            send_bar(alike ? like_bar(base, k == n - 1) : rand_bar(k == n - 1));
    endtask

    task automatic test_directed();
        t_in_word b;
        b = '0;
        b.last_bar = 1'b1;
        send_bar(b);
        b = '1;
        send_bar(b);
        b = '{16'hFFFF, 16'hFFFF, 14'd0, 16'hFFFF, 16'hFFFF, 1'b0};
        send_bar(b);
        b = '{16'h0000, 16'h0000, 14'd11520, 16'hFFFF, 16'hFFFF, 1'b1};
        send_bar(b);
        b = '{16'h1000, 16'h2000, 14'd100, 16'd300, 16'd800, 1'b0};
        send_bar(b);
        b = '{16'h1400, 16'h2300, 14'd150, 16'd320, 16'd820, 1'b1};
        send_bar(b);
        b = '{16'h1000, 16'h2000, 14'd11500, 16'd300, 16'd800, 1'b0};
        send_bar(b);
        b = '{16'h1400, 16'h2300, 14'd16383, 16'd320, 16'd820, 1'b1};
        send_bar(b);
        send_frame(10, 1);
        send_frame(9, 0);
    endtask

    task automatic test_config();
        write_reg(CFG_ANGLE_TOL, 14'd11520);
        write_reg(CFG_SIZE_DIV, 4'd0);
        send_frame(8, 0);
        send_frame(3, 0);
        write_reg(CFG_ANGLE_TOL, 14'd0);
        write_reg(CFG_SIZE_DIV, 4'd15);
        send_frame(8, 1);
        write_reg(CFG_ANGLE_TOL, 14'd16383);
        write_reg(CFG_SIZE_DIV, 4'd1);
        send_frame(5, 0);
        write_reg(CFG_ANGLE_TOL, 14'd128);
        write_reg(CFG_SIZE_DIV, 4'd5);
    endtask

    task automatic test_random(int bars);
        int sent;
        int n;
        sent = 0;
        while (sent < bars) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(11, 9) : $urandom_range(8, 1);
            send_frame(n, $urandom_range(3) != 0);
            sent += n;
        end
    endtask

    task automatic test_backpressure();
        hold_off = 400;
        send_frame(8, 1);
        send_frame(8, 1);
        send_frame(4, 1);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config();
        send_idle_pct = 7;
        recv_idle_pct = 62;
        test_random(90);
        send_idle_pct = 62;
        recv_idle_pct = 7;
        test_random(90);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(60);
        test_backpressure();
        drain();
        if (errors == 0)
            $display("tb_light_bar_pair_matcher_top passed");
        else
            $display("tb_light_bar_pair_matcher_top failed");
        $finish;
    end

endmodule
